/* rtl/core/assert_macros.svh */
// assertion macros shared by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, clocked on clk, off while rst_n is low
`define UFG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define UFG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UFG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ufg_pkg.sv */
// shared constants, codes and helpers of the udp frame generator
package ufg_pkg;

  // operation codes on the input channel
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_MAC    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MAC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_IP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_IP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOTAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS   = 3'd6;

  // field widths
  localparam int FLEN_CFG_W = 14;
  localparam int CNT_W      = 32;
  localparam int CSUM_W     = 16;

  // frame geometry
  localparam int MAX_FRAME_DEF = 9018;
  localparam int MIN_FRAME     = 14 + 20 + 8;

  // reset values
  localparam logic [47:0]      DEST_MAC_RST    = 48'h0080_C879_B3CB;
  localparam int               FRAME_LEN_RST   = 60;
  localparam logic [CNT_W-1:0] FRAME_TOTAL_RST = 32'd100000;

  // address table: one entry per address register
  localparam int ADR_DEPTH = 4;
  localparam int ADR_AW    = 2;
  localparam int ADR_W     = 48;

  localparam logic [ADR_AW-1:0] ENT_DEST_MAC   = 2'd0;
  localparam logic [ADR_AW-1:0] ENT_SOURCE_MAC = 2'd1;
  localparam logic [ADR_AW-1:0] ENT_SOURCE_IP  = 2'd2;
  localparam logic [ADR_AW-1:0] ENT_DEST_IP    = 2'd3;

  // which address entry feeds a given header byte
  function automatic logic [ADR_AW-1:0] adr_entry(input logic [5:0] i);
    logic [ADR_AW-1:0] e;
    case (i) inside
      [6'd0:6'd5]:   e = ENT_DEST_MAC;
      [6'd6:6'd11]:  e = ENT_SOURCE_MAC;
      [6'd26:6'd29]: e = ENT_SOURCE_IP;
      [6'd30:6'd33]: e = ENT_DEST_IP;
      default:       e = ENT_DEST_MAC;
    endcase
    return e;
  endfunction

  // value an entry holds before its first write
  function automatic logic [ADR_W-1:0] adr_reset(input logic [ADR_AW-1:0] e);
    return (e == ENT_DEST_MAC) ? DEST_MAC_RST : '0;
  endfunction

endpackage

/* rtl/core/udp_frame_generator.sv */
// top level of the udp frame generator
// - input channel (in_valid/in_ready) carries one command per transfer:
//   tick, start run or stop run, plus the sink_ready flag of that tick
// - every input transfer yields exactly one result transfer on the out_
//   channel: an optional frame byte with last flag, the frames sent count,
//   busy and stopped status
// - configuration is a plain write port (cfg_we, cfg_index, cfg_wdata);
//   writes are dropped while a run is in progress
// output register and throughput
// - each result is registered on its input transfer; one input
//   transfer per cycle sustained while out_ready is high, the output
//   register frees itself in the same cycle it is taken
// - header address bytes come from a 4-entry address ram, prefetched at
//   the next byte offset so its registered read never holds up a byte
// reset
// - synchronous on rst_n; address ram entries read as their reset values
//   until written, no clearing pass; run is idle
// stall
// - with out_valid high and out_ready low, in_ready drops and all run
//   state holds until the result is taken
module udp_frame_generator #(
  parameter int MAX_FRAME = ufg_pkg::MAX_FRAME_DEF,
  localparam int LEN_W = $clog2(MAX_FRAME + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_operation,
  input  logic                             in_sink_ready,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_frame_byte,
  output logic                             out_byte_valid,
  output logic                             out_frame_last,
  output logic [ufg_pkg::CNT_W-1:0]        out_frames_sent,
  output logic                             out_busy_res,
  output logic                             out_run_stopped,
  // configuration port
  input  logic                             cfg_we,
  input  logic [ufg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ufg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // run phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SEND = 2'd1;
  localparam logic [1:0] PH_GAP  = 2'd2;

  localparam int CW = ufg_pkg::CNT_W;
  localparam int AW = ufg_pkg::ADR_AW;

  // run state
  logic [1:0]                  phase_r, phase_nxt;
  logic [LEN_W-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]               gap_r, gap_nxt;
  logic [CW-1:0]               left_r, left_nxt;
  logic [CW-1:0]               sent_r, sent_nxt;
  logic [ufg_pkg::CSUM_W-1:0]  csum_r, csum_nxt;
  logic                        stop_r, stop_nxt;

  // scalar config kept in flops, plus folded ip address sums
  logic [LEN_W-1:0]            flen_r, flen_nxt;
  logic [CW-1:0]               ftotal_r, ftotal_nxt;
  logic [CW-1:0]               gapcfg_r, gapcfg_nxt;
  logic [15:0]                 src_sum_r, src_sum_nxt;
  logic [15:0]                 dst_sum_r, dst_sum_nxt;

  // address ram side
  logic [ufg_pkg::ADR_DEPTH-1:0] adr_vld_r, adr_vld_nxt;
  logic                        adr_we;
  logic [AW-1:0]               adr_waddr;
  logic [ufg_pkg::ADR_W-1:0]   adr_wdata;
  logic [AW-1:0]               adr_raddr;
  logic [ufg_pkg::ADR_W-1:0]   ram_rdata;
  logic [AW-1:0]               rd_addr_r;
  logic                        rd_vld_r;
  logic                        byp_r;
  logic [ufg_pkg::ADR_W-1:0]   byp_data_r;
  logic [ufg_pkg::ADR_W-1:0]   adr_word;

  // output register
  logic                        out_valid_r;
  logic [7:0]                  ob_r, ob_nxt;
  logic                        obv_r, obv_nxt;
  logic                        olast_r, olast_nxt;

  logic                        in_fire;
  logic                        cfg_ok;
  logic [7:0]                  hdr_byte;
  logic                        at_end;
  logic [31:0]                 len_wr;
  logic [16:0]                 ip_hi_lo;
  logic [18:0]                 cs_total;
  logic [16:0]                 cs_fold;
  logic [15:0]                 cs_sum;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign cfg_ok   = cfg_we && (phase_r == PH_IDLE);

  // ---------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------
  assign len_wr   = 32'(cfg_wdata[ufg_pkg::FLEN_CFG_W-1:0]);
  assign ip_hi_lo = 17'(cfg_wdata[31:16]) + 17'(cfg_wdata[15:0]);

  always_comb begin
    flen_nxt    = flen_r;
    ftotal_nxt  = ftotal_r;
    gapcfg_nxt  = gapcfg_r;
    src_sum_nxt = src_sum_r;
    dst_sum_nxt = dst_sum_r;
    if (cfg_ok) begin
      case (cfg_index)
        ufg_pkg::REG_FRAME_LEN: begin
          // saturate into the legal frame range
          if (len_wr < 32'(ufg_pkg::MIN_FRAME)) begin
            flen_nxt = LEN_W'(ufg_pkg::MIN_FRAME);
          end else if (len_wr > 32'(MAX_FRAME)) begin
            flen_nxt = LEN_W'(MAX_FRAME);
          end else begin
            flen_nxt = LEN_W'(len_wr);
          end
        end
        ufg_pkg::REG_FRAME_TOTAL: begin
          // a zero count is dropped
          if (cfg_wdata[CW-1:0] != '0) begin
            ftotal_nxt = cfg_wdata[CW-1:0];
          end
        end
        ufg_pkg::REG_GAP_TICKS: gapcfg_nxt = cfg_wdata[CW-1:0];
        ufg_pkg::REG_SOURCE_IP: src_sum_nxt = ip_hi_lo[15:0] + 16'(ip_hi_lo[16]);
        ufg_pkg::REG_DEST_IP:   dst_sum_nxt = ip_hi_lo[15:0] + 16'(ip_hi_lo[16]);
        default: ;
      endcase
    end
  end

  // address registers live in the ram; indexes 0..3 map onto entries
  assign adr_we    = cfg_ok && (cfg_index <= ufg_pkg::REG_DEST_IP);
  assign adr_waddr = AW'(cfg_index);
  assign adr_wdata = (cfg_index >= ufg_pkg::REG_SOURCE_IP) ?
                     {16'h0000, cfg_wdata[31:0]} : cfg_wdata;

  always_comb begin
    adr_vld_nxt = adr_vld_r;
    if (adr_we) begin
      adr_vld_nxt[adr_waddr] = 1'b1;
    end
  end

  // ---------------------------------------------------------------
  // ip header checksum at start: one's-complement sum, end-around carry
  // ---------------------------------------------------------------
  assign cs_total = 19'(16'h4500) + 19'(16'h0311)
                  + 19'(16'(flen_r) - 16'd14)
                  + 19'(src_sum_r) + 19'(dst_sum_r);
  assign cs_fold  = 17'(cs_total[15:0]) + 17'(cs_total[18:16]);
  assign cs_sum   = cs_fold[15:0] + 16'(cs_fold[16]);

  // ---------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------
  assign at_end = ((LEN_W+1)'(idx_r) + (LEN_W+1)'(1)) >= (LEN_W+1)'(flen_r);

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    gap_nxt   = gap_r;
    left_nxt  = left_r;
    sent_nxt  = sent_r;
    csum_nxt  = csum_r;
    stop_nxt  = stop_r;
    ob_nxt    = ob_r;
    obv_nxt   = obv_r;
    olast_nxt = olast_r;
    if (in_fire) begin
      ob_nxt    = 8'h00;
      obv_nxt   = 1'b0;
      olast_nxt = 1'b0;
      case (in_operation)
        ufg_pkg::OP_START: begin
          // start from idle only, no byte on this transfer
          if (phase_r == PH_IDLE) begin
            csum_nxt  = ~cs_sum;
            left_nxt  = ftotal_r;
            sent_nxt  = '0;
            stop_nxt  = 1'b0;
            idx_nxt   = '0;
            gap_nxt   = '0;
            phase_nxt = PH_SEND;
          end
        end
        ufg_pkg::OP_STOP: begin
          // partial frame is dropped and not counted
          if (phase_r != PH_IDLE) begin
            phase_nxt = PH_IDLE;
            stop_nxt  = 1'b1;
          end
        end
        default: begin
          if (phase_r == PH_SEND) begin
            if (in_sink_ready) begin
              ob_nxt  = hdr_byte;
              obv_nxt = 1'b1;
              if (at_end) begin
                olast_nxt = 1'b1;
                sent_nxt  = sent_r + CW'(1);
                left_nxt  = left_r - CW'(1);
                idx_nxt   = '0;
                if (left_r == CW'(1)) begin
                  phase_nxt = PH_IDLE;
                end else if (gapcfg_r != '0) begin
                  gap_nxt   = gapcfg_r;
                  phase_nxt = PH_GAP;
                end
              end else begin
                idx_nxt = idx_r + LEN_W'(1);
              end
            end
          end else if (phase_r == PH_GAP) begin
            // gap ticks count whether or not the sink is ready
            gap_nxt = gap_r - CW'(1);
            if (gap_r == CW'(1)) begin
              phase_nxt = PH_SEND;
            end
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // address ram, read ahead at the next byte offset
  // ---------------------------------------------------------------
  assign adr_raddr = ufg_pkg::adr_entry(idx_nxt[5:0]);

  ufg_ram #(
    .WIDTH (ufg_pkg::ADR_W),
    .DEPTH (ufg_pkg::ADR_DEPTH)
  ) u_adr_ram (
    .clk   (clk),
    .we    (adr_we),
    .waddr (adr_waddr),
    .wdata (adr_wdata),
    .raddr (adr_raddr),
    .rdata (ram_rdata)
  );

  // forward a write that lands on the entry being read, unwritten
  // entries read as their reset value
  assign adr_word = byp_r    ? byp_data_r :
                    rd_vld_r ? ram_rdata  : ufg_pkg::adr_reset(rd_addr_r);

  ufg_hdr #(
    .LEN_W (LEN_W)
  ) u_hdr (
    .idx       (idx_r),
    .adr_word  (adr_word),
    .frame_len (flen_r),
    .csum      (csum_r),
    .hdr_byte  (hdr_byte)
  );

  // ---------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      idx_r       <= '0;
      gap_r       <= '0;
      left_r      <= '0;
      sent_r      <= '0;
      csum_r      <= '0;
      stop_r      <= 1'b0;
      flen_r      <= LEN_W'(ufg_pkg::FRAME_LEN_RST);
      ftotal_r    <= ufg_pkg::FRAME_TOTAL_RST;
      gapcfg_r    <= '0;
      src_sum_r   <= '0;
      dst_sum_r   <= '0;
      adr_vld_r   <= '0;
      rd_vld_r    <= 1'b0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      gap_r       <= gap_nxt;
      left_r      <= left_nxt;
      sent_r      <= sent_nxt;
      csum_r      <= csum_nxt;
      stop_r      <= stop_nxt;
      flen_r      <= flen_nxt;
      ftotal_r    <= ftotal_nxt;
      gapcfg_r    <= gapcfg_nxt;
      src_sum_r   <= src_sum_nxt;
      dst_sum_r   <= dst_sum_nxt;
      adr_vld_r   <= adr_vld_nxt;
      rd_vld_r    <= adr_vld_r[adr_raddr];
      byp_r       <= adr_we && (adr_waddr == adr_raddr);
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_addr_r  <= adr_raddr;
    byp_data_r <= adr_wdata;
    ob_r       <= ob_nxt;
    obv_r      <= obv_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_frame_byte  = ob_r;
  assign out_byte_valid  = obv_r;
  assign out_frame_last  = olast_r;
  // status follows the run state, which only moves on an input transfer
  assign out_frames_sent = sent_r;
  assign out_busy_res    = (phase_r != PH_IDLE);
  assign out_run_stopped = stop_r;

endmodule

/* rtl/core/ufg_ram.sv */
// generic single-write, single-read ram with registered read
module ufg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ufg_hdr.sv */
// header byte formatter: byte of the frame at a given offset
module ufg_hdr #(
  parameter int LEN_W = 14
) (
  input  logic [LEN_W-1:0]              idx,
  input  logic [ufg_pkg::ADR_W-1:0]     adr_word,
  input  logic [LEN_W-1:0]              frame_len,
  input  logic [ufg_pkg::CSUM_W-1:0]    csum,
  output logic [7:0]                    hdr_byte
);

  logic [5:0]  i6;
  logic        in_hdr;
  logic [15:0] ip_len;
  logic [15:0] udp_len;
  logic [2:0]  sh;
  logic [7:0]  adr_byte;
  logic [7:0]  b;

  assign i6      = idx[5:0];
  assign in_hdr  = idx < LEN_W'(ufg_pkg::MIN_FRAME);
  assign ip_len  = 16'(frame_len) - 16'd14;
  assign udp_len = 16'(frame_len) - 16'd34;

  // byte position inside the address word, most significant first
  always_comb begin
    case (i6) inside
      [6'd0:6'd5]:   sh = 3'(6'd5 - i6);
      [6'd6:6'd11]:  sh = 3'(6'd11 - i6);
      [6'd26:6'd29]: sh = 3'(6'd29 - i6);
      [6'd30:6'd33]: sh = 3'(6'd33 - i6);
      default:       sh = 3'd0;
    endcase
  end

  assign adr_byte = 8'(adr_word >> {sh, 3'b000});

  always_comb begin
    case (i6) inside
      [6'd0:6'd11], [6'd26:6'd33]: b = adr_byte;
      6'd12:         b = 8'h08;
      6'd14:         b = 8'h45;
      6'd16:         b = ip_len[15:8];
      6'd17:         b = ip_len[7:0];
      6'd22:         b = 8'd3;
      6'd23:         b = 8'd17;
      6'd24:         b = csum[15:8];
      6'd25:         b = csum[7:0];
      6'd35, 6'd37:  b = 8'd9;
      6'd38:         b = udp_len[15:8];
      6'd39:         b = udp_len[7:0];
      default:       b = 8'h00;
    endcase
  end

  // payload past the headers is all zero
  assign hdr_byte = in_hdr ? b : 8'h00;

endmodule

/* rtl/core/ufg_checker.sv */
// port-level checker for the udp frame generator, bound to the top level
`include "assert_macros.svh"

module ufg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_frame_byte,
  input logic       out_byte_valid,
  input logic       out_frame_last,
  input logic       out_busy_res
);

  `UFG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_frame_byte) && $stable(out_frame_last), "stalled result changed")
  `UFG_ASSERT_IMPL(a_idle_byte_zero, out_valid && !out_byte_valid, out_frame_byte == 8'h00 && !out_frame_last, "byte or last without a sent byte")
  `UFG_ASSERT_IMPL(a_last_has_byte, out_valid && out_frame_last, out_byte_valid, "frame last without byte")
  `UFG_ASSERT(a_byte_busy, !(out_valid && out_byte_valid) || out_busy_res || out_frame_last, "run ended without a final byte")

endmodule

bind udp_frame_generator ufg_checker u_ufg_checker (.*);
